### rtl/core/rational_arith_reduce_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rational arithmetic block
// Immediate-consequence and next-cycle property wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational_arith_reduce: property failed");
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational_arith_reduce: property failed");
`else
`define RAR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Opcodes, status codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package rar_pkg;

   // fixed widths
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int RES_W    = 32;
   localparam int DNUM_W   = 16;
   localparam int DDEN_W   = 15;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;

   // opcodes
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NORM = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERODEN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_NUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_DEN = 1'b1;

endpackage

### rtl/core/rar_div_cell.sv
// ----------------------------------------------------------------------------
// rar_div_cell
// One restoring-division step: shifts in one dividend bit, makes one quotient bit.
// ----------------------------------------------------------------------------
module rar_div_cell #(
   parameter int UW = 34
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [UW-1:0] in_rem,
   input  logic [UW-1:0] in_dvd,
   input  logic [UW-1:0] in_quo,
   input  logic [UW-1:0] in_dsr,
   output logic          out_valid,
   output logic [UW-1:0] out_rem,
   output logic [UW-1:0] out_dvd,
   output logic [UW-1:0] out_quo,
   output logic [UW-1:0] out_dsr
);

   logic          valid_ff;
   logic [UW-1:0] rem_ff, rem_in;
   logic [UW-1:0] dvd_ff, quo_ff, dsr_ff;
   logic [UW:0]   shifted, diff;
   logic          ge;

   // trial subtract
   assign shifted = {in_rem, in_dvd[UW-1]};
   assign diff    = shifted - {1'b0, in_dsr};
   assign ge      = !diff[UW];
   assign rem_in  = ge ? diff[UW-1:0] : shifted[UW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= {in_dvd[UW-2:0], 1'b0};
      quo_ff <= {in_quo[UW-2:0], ge};
      dsr_ff <= in_dsr;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dvd   = dvd_ff;
   assign out_quo   = quo_ff;
   assign out_dsr   = dsr_ff;

endmodule

### rtl/core/rar_div_chain.sv
// ----------------------------------------------------------------------------
// rar_div_chain
// Row of UW division cells: quotient and remainder come out of the last cell.
// ----------------------------------------------------------------------------
module rar_div_chain #(
   parameter int UW = 34
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [UW-1:0] dividend,
   input  logic [UW-1:0] divisor,
   output logic          out_valid,
   output logic [UW-1:0] quotient,
   output logic [UW-1:0] remainder
);

   logic          vld [UW+1];
   logic [UW-1:0] rem [UW+1];
   logic [UW-1:0] dvd [UW+1];
   logic [UW-1:0] quo [UW+1];
   logic [UW-1:0] dsr [UW+1];

   // head of the row
   assign vld[0] = in_valid;
   assign rem[0] = '0;
   assign dvd[0] = dividend;
   assign quo[0] = '0;
   assign dsr[0] = divisor;

   for (genvar i = 0; i < UW; i++) begin : g_cell
      rar_div_cell #(.UW(UW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (vld[i]),
         .in_rem   (rem[i]),
         .in_dvd   (dvd[i]),
         .in_quo   (quo[i]),
         .in_dsr   (dsr[i]),
         .out_valid(vld[i+1]),
         .out_rem  (rem[i+1]),
         .out_dvd  (dvd[i+1]),
         .out_quo  (quo[i+1]),
         .out_dsr  (dsr[i+1])
      );
   end

   assign out_valid = vld[UW];
   assign quotient  = quo[UW];
   assign remainder = rem[UW];

endmodule

### rtl/core/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Add, subtract, multiply or divide two fractions, or normalize one, reduced by their gcd.
//
//   channel   ports                                     handshake
//   request   req_cmd, req_a_num/den, req_b_num/den     start, busy
//   response  rsp_res_num, rsp_res_den, rsp_status      rsp_valid (1 cycle)
//   csr       csr_index, csr_wdata                      csr_we
//
// One word at a time. A normalization runs Euclid's loop, up to about 1.5*UW
// steps, unless a part is zero; every remainder passes the UW-cell divider
// row (UW = 2*AW), and when the gcd exceeds 1 the two final quotients pass
// it as well. Normalize runs one normalization; the other commands run two,
// then, but for a divide by zero, form the three products and run a third.
// The response is registered.
// Reset is synchronous; defaults return to 0/1. The receiver cannot stall:
// rsp_valid is high for exactly one cycle, with busy already low.
// ----------------------------------------------------------------------------
`include "rational_arith_reduce_assert.svh"

module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rar_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]      req_b_den,
   output logic                                 rsp_valid,
   output logic signed [rar_pkg::RES_W-1:0]     rsp_res_num,
   output logic signed [rar_pkg::RES_W-1:0]     rsp_res_den,
   output logic [rar_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                 csr_we,
   input  logic [rar_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rar_pkg::CSR_W-1:0]            csr_wdata
);

   import rar_pkg::*;

   // operand width after normalization (must also hold the default numerator)
   localparam int AW = (OPERAND_WIDTH + 1 > DNUM_W) ? OPERAND_WIDTH + 1 : DNUM_W;
   localparam int UW = 2 * AW;
   localparam int SW = 2 * AW + 1;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_NORM     = 11'b000_0000_0010,
      S_GCD      = 11'b000_0000_0100,
      S_GCD_WAIT = 11'b000_0000_1000,
      S_QN       = 11'b000_0001_0000,
      S_QN_WAIT  = 11'b000_0010_0000,
      S_QD       = 11'b000_0100_0000,
      S_QD_WAIT  = 11'b000_1000_0000,
      S_NEXT     = 11'b001_0000_0000,
      S_MUL      = 11'b010_0000_0000,
      S_FORM     = 11'b100_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      PH_A = 3'b001,
      PH_B = 3'b010,
      PH_R = 3'b100
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic signed [AW-1:0]  bn_raw_ff, bn_raw_in, bd_raw_ff, bd_raw_in;
   logic signed [AW-1:0]  an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic signed [SW-1:0]  nn_ff, nn_in, nd_ff, nd_in;
   logic [UW-1:0]         gx_ff, gx_in, gy_ff, gy_in;
   logic signed [UW-1:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [1:0]            mul_idx_ff, mul_idx_in;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [RES_W-1:0] rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DNUM_W-1:0]     dnum_ff;
   logic [DDEN_W-1:0]     dden_ff;

   logic signed [SW-1:0]  dflt_num, dflt_den, nn_neg, nd_neg, q_ext, sum;
   logic [UW-1:0]         nn_mag, nd_mag;
   logic signed [AW-1:0]  mul_x, mul_y;
   logic signed [UW-1:0]  prod;
   logic                  two_operand;

   logic                  div_in_valid, div_out_valid;
   logic [UW-1:0]         div_dvd, div_dsr, div_quo, div_rem;

   // fallback fraction, zero denominator read as one
   assign dflt_num = SW'($signed(dnum_ff));
   assign dflt_den = (dden_ff == '0) ? SW'(1) : SW'({1'b0, dden_ff});

   assign nn_neg = -nn_ff;
   assign nd_neg = -nd_ff;
   assign nn_mag = nn_ff[SW-1] ? nn_neg[UW-1:0] : nn_ff[UW-1:0];
   assign nd_mag = nd_ff[SW-1] ? nd_neg[UW-1:0] : nd_ff[UW-1:0];
   assign q_ext  = $signed({1'b0, div_quo});

   assign two_operand = (cmd_ff == CMD_ADD) || (cmd_ff == CMD_SUB) ||
                        (cmd_ff == CMD_MUL) || (cmd_ff == CMD_DIV);

   // shared multiplier, one product per cycle
   always_comb begin
      case (mul_idx_ff)
         2'd0: begin
            mul_x = an_ff;
            mul_y = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         2'd1: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         default: begin
            mul_x = ad_ff;
            mul_y = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
         end
      endcase
   end
   assign prod = mul_x * mul_y;

   // numerator combine
   always_comb begin
      case (cmd_ff)
         CMD_ADD: sum = SW'(p0_ff) + SW'(p1_ff);
         CMD_SUB: sum = SW'(p0_ff) - SW'(p1_ff);
         default: sum = SW'(p0_ff);
      endcase
   end

   // divider row feed
   always_comb begin
      div_in_valid = 1'b0;
      div_dvd      = gx_ff;
      div_dsr      = gy_ff;
      case (state_ff)
         S_GCD: div_in_valid = (gy_ff != '0);
         S_QN: begin
            div_in_valid = 1'b1;
            div_dvd      = nn_mag;
            div_dsr      = gx_ff;
         end
         S_QD: begin
            div_in_valid = 1'b1;
            div_dvd      = nd_mag;
            div_dsr      = gx_ff;
         end
         default: ;
      endcase
   end

   rar_div_chain #(.UW(UW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_in_valid),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .out_valid(div_out_valid),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cmd_in        = cmd_ff;
      bn_raw_in     = bn_raw_ff;
      bd_raw_in     = bd_raw_ff;
      an_in         = an_ff;
      ad_in         = ad_ff;
      bn_in         = bn_ff;
      bd_in         = bd_ff;
      nn_in         = nn_ff;
      nd_in         = nd_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      mul_idx_in    = mul_idx_ff;
      flag_in       = flag_ff;
      rsp_valid_in  = 1'b0;
      rsp_num_in    = rsp_num_ff;
      rsp_den_in    = rsp_den_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = req_cmd;
               bn_raw_in = AW'(req_b_num);
               bd_raw_in = AW'(req_b_den);
               nn_in     = SW'(req_a_num);
               nd_in     = SW'(req_a_den);
               phase_in  = PH_A;
               flag_in   = 1'b0;
               state_in  = S_NORM;
            end
         end
         S_NORM: begin
            if (nd_ff == '0) begin
               flag_in  = 1'b1;
               nn_in    = dflt_num;
               nd_in    = dflt_den;
               state_in = S_NEXT;
            end else begin
               if (nn_ff[SW-1] && nd_ff[SW-1]) begin
                  nn_in = nn_neg;
                  nd_in = nd_neg;
               end
               gx_in    = nn_mag;
               gy_in    = nd_mag;
               state_in = (nn_ff == '0) ? S_NEXT : S_GCD;
            end
         end
         S_GCD: begin
            if (gy_ff == '0) begin
               state_in = (gx_ff > UW'(1)) ? S_QN : S_NEXT;
            end else begin
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (div_out_valid) begin
               gx_in    = gy_ff;
               gy_in    = div_rem;
               state_in = S_GCD;
            end
         end
         S_QN: state_in = S_QN_WAIT;
         S_QN_WAIT: begin
            if (div_out_valid) begin
               nn_in    = nn_ff[SW-1] ? -q_ext : q_ext;
               state_in = S_QD;
            end
         end
         S_QD: state_in = S_QD_WAIT;
         S_QD_WAIT: begin
            if (div_out_valid) begin
               nd_in    = nd_ff[SW-1] ? -q_ext : q_ext;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            case (phase_ff)
               PH_A: begin
                  an_in = nn_ff[AW-1:0];
                  ad_in = nd_ff[AW-1:0];
                  if (two_operand) begin
                     nn_in    = SW'(bn_raw_ff);
                     nd_in    = SW'(bd_raw_ff);
                     phase_in = PH_B;
                     state_in = S_NORM;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_num_in    = nn_ff[RES_W-1:0];
                     rsp_den_in    = nd_ff[RES_W-1:0];
                     rsp_status_in = flag_ff ? ST_ZERODEN : ST_OK;
                     state_in      = S_IDLE;
                  end
               end
               PH_B: begin
                  bn_in = nn_ff[AW-1:0];
                  bd_in = nd_ff[AW-1:0];
                  if ((cmd_ff == CMD_DIV) && (nn_ff == '0)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_num_in    = dflt_num[RES_W-1:0];
                     rsp_den_in    = dflt_den[RES_W-1:0];
                     rsp_status_in = ST_DIVZERO;
                     state_in      = S_IDLE;
                  end else begin
                     mul_idx_in = 2'd0;
                     state_in   = S_MUL;
                  end
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_num_in    = nn_ff[RES_W-1:0];
                  rsp_den_in    = nd_ff[RES_W-1:0];
                  rsp_status_in = flag_ff ? ST_ZERODEN : ST_OK;
                  state_in      = S_IDLE;
               end
            endcase
         end
         S_MUL: begin
            case (mul_idx_ff)
               2'd0:    p0_in = prod;
               2'd1:    p1_in = prod;
               default: p2_in = prod;
            endcase
            mul_idx_in = mul_idx_ff + 2'd1;
            if (mul_idx_ff == 2'd2) begin
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            nn_in    = sum;
            nd_in    = SW'(p2_ff);
            phase_in = PH_R;
            state_in = S_NORM;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      cmd_ff        <= cmd_in;
      bn_raw_ff     <= bn_raw_in;
      bd_raw_ff     <= bd_raw_in;
      an_ff         <= an_in;
      ad_ff         <= ad_in;
      bn_ff         <= bn_in;
      bd_ff         <= bd_in;
      nn_ff         <= nn_in;
      nd_ff         <= nd_in;
      gx_ff         <= gx_in;
      gy_ff         <= gy_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      mul_idx_ff    <= mul_idx_in;
      flag_ff       <= flag_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_den_ff    <= rsp_den_in;
      rsp_status_ff <= rsp_status_in;
   end

   // default fraction registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dnum_ff <= '0;
         dden_ff <= DDEN_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEFAULT_NUM: dnum_ff <= csr_wdata[DNUM_W-1:0];
            CSR_DEFAULT_DEN: dden_ff <= csr_wdata[DDEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_status  = rsp_status_ff;

   // checks
   `RAR_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, state_ff == S_IDLE)
   `RAR_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `RAR_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   `RAR_ASSERT_IMPL(a_div_nonzero, clock, reset, div_in_valid, div_dsr != '0)

endmodule
